### sv/cocv_pkg.sv
// Shared types and constants for the coupon offer code validator.
`timescale 1ns / 1ps

package cocv_pkg;

    localparam int MAX_LENGTH_DEFAULT  = 255;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 8;
    localparam int REM_W  = 4;
    localparam int ST_W   = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_SIX  = 8'h36;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // Funder and serial fields carry this many digits beyond their length digit.
    localparam logic [REM_W-1:0] FIELD_BASE_LEN = 4'd6;

    typedef enum logic [ST_W-1:0] {
        ST_OK             = 4'd0,
        ST_NONDIGIT       = 4'd1,
        ST_NO_FORMAT      = 4'd2,
        ST_BAD_FORMAT     = 4'd3,
        ST_NO_FUNDER_LEN  = 4'd4,
        ST_BAD_FUNDER_LEN = 4'd5,
        ST_SHORT_FUNDER   = 4'd6,
        ST_SHORT_OFFER    = 4'd7,
        ST_NO_SERIAL_LEN  = 4'd8,
        ST_SHORT_SERIAL   = 4'd9,
        ST_EXCESS         = 4'd10
    } status_t;

    typedef enum logic [6:0] {
        PH_FORMAT     = 7'b0000001,
        PH_FUNDER_LEN = 7'b0000010,
        PH_FUNDER     = 7'b0000100,
        PH_OFFER      = 7'b0001000,
        PH_SERIAL_LEN = 7'b0010000,
        PH_SERIAL     = 7'b0100000,
        PH_DONE       = 7'b1000000
    } phase_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic              has_char;
        logic              last;
        logic              digit;
        logic              format_ok;
        logic              len_ok;
        logic [REM_W-1:0]  digit_value;
    } item_t;

endpackage

### sv/coupon_offer_code_validator.sv
// Top level of the coupon offer code validator: front, queue and back joined.
// Path: a final item is registered in the front, written into the queue, and then
//   loads the status register, which raises result_valid.
// Throughput: one item per cycle, the back's field walk included, while no result is held.
// Reset: rst_n asynchronous, active low; clears the field walker, queue and valid flags.
`timescale 1ns / 1ps

module coupon_offer_code_validator #(
    parameter int MAX_LENGTH  = cocv_pkg::MAX_LENGTH_DEFAULT,
    parameter int QUEUE_DEPTH = cocv_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          has_char,
    input  logic [cocv_pkg::CHAR_W-1:0]   character,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [cocv_pkg::ST_W-1:0]     status,
    output logic [cocv_pkg::POS_W-1:0]    error_position,
    output logic [cocv_pkg::POS_W-1:0]    error_length
);

    // Front to queue: classified items (digit, format and length-digit checks).
    logic            cls_valid;
    logic            cls_ready;
    cocv_pkg::item_t cls_item;

    // Queue to back.
    logic            q_valid;
    logic            q_ready;
    cocv_pkg::item_t q_item;

    // Classify each character; drop items that carry neither a character nor the end.
    cocv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .has_char   (has_char),
        .character  (character),
        .last       (last),
        .cls_valid  (cls_valid),
        .cls_ready  (cls_ready),
        .cls_item   (cls_item)
    );

    // Hold a few classified items so the front keeps taking input while the
    // result register waits on a stalled consumer.
    cocv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_ready (cls_ready),
        .push_item  (cls_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Walk the fields, latch the first non-digit and first field error, and
    // register one status at the end of each string.
    cocv_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cls_valid      (q_valid),
        .cls_ready      (q_ready),
        .cls_item       (q_item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .error_position (error_position),
        .error_length   (error_length)
    );

endmodule

### sv/cocv_front.sv
// Front stage: accepts items, drops empty non-final items, classifies the character.
`timescale 1ns / 1ps

module cocv_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            has_char,
    input  logic [cocv_pkg::CHAR_W-1:0]     character,
    input  logic                            last,
    output logic                            cls_valid,
    input  logic                            cls_ready,
    output cocv_pkg::item_t                 cls_item
);

    logic            valid_reg;
    logic            valid_next;
    cocv_pkg::item_t item_reg;
    cocv_pkg::item_t item_next;
    logic            accept;
    logic            keep;
    logic            digit;

    assign item_ready = !valid_reg || cls_ready;
    assign accept     = item_valid && item_ready;
    // An item with no character that does not end the string changes nothing.
    assign keep       = has_char || last;
    assign digit      = (character >= cocv_pkg::CHAR_ZERO) && (character <= cocv_pkg::CHAR_NINE);

    always_comb
    begin
        item_next.has_char    = has_char;
        item_next.last        = last;
        item_next.digit       = digit;
        item_next.format_ok   = (character == cocv_pkg::CHAR_ZERO) ||
                                (character == cocv_pkg::CHAR_ONE);
        item_next.len_ok      = (character <= cocv_pkg::CHAR_SIX);
        item_next.digit_value = digit ? cocv_pkg::REM_W'(character - cocv_pkg::CHAR_ZERO)
                                      : '0;
        valid_next = valid_reg && !cls_ready;
        if (accept && keep)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            item_reg <= item_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls_item  = item_reg;

endmodule

### sv/cocv_queue.sv
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps

module cocv_queue #(
    parameter int DEPTH = cocv_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  cocv_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cocv_pkg::item_t pop_item
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cocv_pkg::item_t entry_reg [DEPTH];
    logic [IW-1:0]   wr_ptr_reg;
    logic [IW-1:0]   wr_ptr_next;
    logic [IW-1:0]   rd_ptr_reg;
    logic [IW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/cocv_back.sv
// Back stage: walks the coupon fields, tracks errors, and registers the status.
`timescale 1ns / 1ps

module cocv_back #(
    parameter int MAX_LENGTH = cocv_pkg::MAX_LENGTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cls_valid,
    output logic                          cls_ready,
    input  cocv_pkg::item_t               cls_item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [cocv_pkg::ST_W-1:0]     status,
    output logic [cocv_pkg::POS_W-1:0]    error_position,
    output logic [cocv_pkg::POS_W-1:0]    error_length
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    logic [CW-1:0]                  count_reg,    count_next;
    cocv_pkg::phase_t               phase_reg,    phase_next;
    logic [CW-1:0]                  start_reg,    start_next;
    logic [cocv_pkg::REM_W-1:0]     rem_reg,      rem_next;
    logic                           nd_seen_reg,  nd_seen_next;
    logic [CW-1:0]                  nd_pos_reg,   nd_pos_next;
    cocv_pkg::status_t              early_reg,    early_next;
    logic [CW-1:0]                  early_pos_reg, early_pos_next;

    logic                           out_valid_reg, out_valid_next;
    cocv_pkg::status_t              status_reg,   status_next;
    logic [cocv_pkg::POS_W-1:0]     pos_reg,      pos_next;
    logic [cocv_pkg::POS_W-1:0]     len_reg,      len_next;

    logic                           pop;
    logic [CW-1:0]                  pos;
    logic [CW-1:0]                  nxt;
    logic [cocv_pkg::REM_W-1:0]     rem_dec;
    logic [CW-1:0]                  res_pos;
    logic [CW-1:0]                  res_len;

    assign cls_ready = !out_valid_reg || result_ready;
    assign pop       = cls_valid && cls_ready;
    assign pos       = count_reg;
    assign nxt       = (count_reg == CW'(MAX_LENGTH)) ? count_reg : count_reg + 1'b1;
    assign rem_dec   = rem_reg - 1'b1;

    always_comb
    begin
        count_next     = count_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        rem_next       = rem_reg;
        nd_seen_next   = nd_seen_reg;
        nd_pos_next    = nd_pos_reg;
        early_next     = early_reg;
        early_pos_next = early_pos_reg;
        out_valid_next = out_valid_reg && !result_ready;
        status_next    = status_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        res_pos        = '0;
        res_len        = '0;

        if (pop && cls_item.has_char)
        begin
            count_next = nxt;
            if (!cls_item.digit && !nd_seen_reg)
            begin
                nd_seen_next = 1'b1;
                nd_pos_next  = pos;
            end
            if (early_reg == cocv_pkg::ST_OK)
            begin
                case (phase_reg)
                    cocv_pkg::PH_FORMAT:
                    begin
                        if (!cls_item.format_ok)
                        begin
                            early_next     = cocv_pkg::ST_BAD_FORMAT;
                            early_pos_next = pos;
                        end
                        else
                        begin
                            phase_next = cocv_pkg::PH_FUNDER_LEN;
                        end
                    end
                    cocv_pkg::PH_FUNDER_LEN:
                    begin
                        if (!cls_item.len_ok)
                        begin
                            early_next     = cocv_pkg::ST_BAD_FUNDER_LEN;
                            early_pos_next = pos;
                        end
                        else
                        begin
                            rem_next   = cls_item.digit_value + cocv_pkg::FIELD_BASE_LEN;
                            start_next = nxt;
                            phase_next = cocv_pkg::PH_FUNDER;
                        end
                    end
                    cocv_pkg::PH_FUNDER:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            rem_next   = cocv_pkg::FIELD_BASE_LEN;
                            start_next = nxt;
                            phase_next = cocv_pkg::PH_OFFER;
                        end
                    end
                    cocv_pkg::PH_OFFER:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            phase_next = cocv_pkg::PH_SERIAL_LEN;
                        end
                    end
                    cocv_pkg::PH_SERIAL_LEN:
                    begin
                        // A non-digit length counts as zero; the non-digit wins anyway.
                        rem_next   = cls_item.digit_value + cocv_pkg::FIELD_BASE_LEN;
                        start_next = nxt;
                        phase_next = cocv_pkg::PH_SERIAL;
                    end
                    cocv_pkg::PH_SERIAL:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            start_next = nxt;
                            phase_next = cocv_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                        early_next     = cocv_pkg::ST_EXCESS;
                        early_pos_next = pos;
                    end
                endcase
            end
        end

        if (pop && cls_item.last)
        begin
            if (nd_seen_next)
            begin
                status_next = cocv_pkg::ST_NONDIGIT;
                res_pos     = nd_pos_next;
                res_len     = CW'(1);
            end
            else if (early_next == cocv_pkg::ST_EXCESS)
            begin
                status_next = cocv_pkg::ST_EXCESS;
                res_pos     = early_pos_next;
                res_len     = count_next - early_pos_next;
            end
            else if (early_next != cocv_pkg::ST_OK)
            begin
                status_next = early_next;
                res_pos     = early_pos_next;
                res_len     = CW'(1);
            end
            else
            begin
                case (phase_next)
                    cocv_pkg::PH_FORMAT:     status_next = cocv_pkg::ST_NO_FORMAT;
                    cocv_pkg::PH_FUNDER_LEN: status_next = cocv_pkg::ST_NO_FUNDER_LEN;
                    cocv_pkg::PH_FUNDER:     status_next = cocv_pkg::ST_SHORT_FUNDER;
                    cocv_pkg::PH_OFFER:      status_next = cocv_pkg::ST_SHORT_OFFER;
                    cocv_pkg::PH_SERIAL_LEN: status_next = cocv_pkg::ST_NO_SERIAL_LEN;
                    cocv_pkg::PH_SERIAL:     status_next = cocv_pkg::ST_SHORT_SERIAL;
                    default:                 status_next = cocv_pkg::ST_OK;
                endcase
                if (phase_next == cocv_pkg::PH_FORMAT ||
                    phase_next == cocv_pkg::PH_FUNDER_LEN ||
                    phase_next == cocv_pkg::PH_SERIAL_LEN)
                begin
                    res_len = count_next;
                end
                else if (phase_next != cocv_pkg::PH_DONE)
                begin
                    if (start_next >= count_next)
                    begin
                        res_len = count_next;
                    end
                    else
                    begin
                        res_pos = start_next;
                        res_len = count_next - start_next;
                    end
                end
            end
            pos_next       = cocv_pkg::POS_W'(res_pos);
            len_next       = cocv_pkg::POS_W'(res_len);
            out_valid_next = 1'b1;

            // Start over for the next string.
            count_next     = '0;
            phase_next     = cocv_pkg::PH_FORMAT;
            start_next     = '0;
            rem_next       = '0;
            nd_seen_next   = 1'b0;
            nd_pos_next    = '0;
            early_next     = cocv_pkg::ST_OK;
            early_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            phase_reg     <= cocv_pkg::PH_FORMAT;
            start_reg     <= '0;
            rem_reg       <= '0;
            nd_seen_reg   <= 1'b0;
            nd_pos_reg    <= '0;
            early_reg     <= cocv_pkg::ST_OK;
            early_pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            rem_reg       <= rem_next;
            nd_seen_reg   <= nd_seen_next;
            nd_pos_reg    <= nd_pos_next;
            early_reg     <= early_next;
            early_pos_reg <= early_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
    end

    assign result_valid   = out_valid_reg;
    assign status         = status_reg;
    assign error_position = pos_reg;
    assign error_length   = len_reg;

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop && cls_item.last))
        else $error("result raised without a final item");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cls_item.last) |=> (count_reg == '0 && phase_reg == cocv_pkg::PH_FORMAT &&
                                    early_reg == cocv_pkg::ST_OK && !nd_seen_reg))
        else $error("state not cleared after string end");

    a_ok_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == cocv_pkg::ST_OK) |->
            (pos_reg == '0 && len_reg == '0))
        else $error("ok status with nonzero position or length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LENGTH))
        else $error("character count past its limit");

endmodule
